[design/srpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MOVE_LEN        = 3'd0,
    REG_RAMP_LEN        = 3'd1,
    REG_START_DELAY     = 3'd2,
    REG_MIN_DELAY       = 3'd3,
    REG_FIRST_TARGET    = 3'd4,
    REG_SAMPLE_SPACING  = 3'd5,
    REG_SAMPLE_COUNT    = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] MOVE_LEN_RST        = 16'd24000;
  localparam logic [14:0] RAMP_LEN_RST        = 15'd800;
  localparam logic [15:0] START_DELAY_RST     = 16'd1000;
  localparam logic [15:0] MIN_DELAY_RST       = 16'd150;
  localparam logic [15:0] FIRST_TARGET_RST    = 16'd800;
  localparam logic [15:0] SAMPLE_SPACING_RST  = 16'd24;
  localparam logic [15:0] SAMPLE_COUNT_RST    = 16'd1;

  typedef struct packed {
    logic [15:0] move_len;
    logic [14:0] ramp_len;
    logic [15:0] start_delay;
    logic [15:0] min_delay;
    logic [15:0] first_target;
    logic [15:0] sample_spacing;
    logic [15:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic        step_level;
    logic        direction_level;
    logic        moving;
    logic        constant_speed;
    logic        sample_due;
    logic [15:0] step_index;
    logic [15:0] samples_taken;
    logic        move_done;
  } res_t;

  // Signed upper bound of the cruise window: move_len - ramp_len.
  function automatic logic signed [16:0] cruise_upper(input cfg_t c);
    cruise_upper = $signed({1'b0, c.move_len}) - $signed({2'b00, c.ramp_len});
  endfunction

  function automatic logic in_cruise(input logic active, input logic [15:0] pos,
                                     input cfg_t c);
    logic signed [16:0] upper;
    upper = cruise_upper(c);
    in_cruise = active && (pos >= {1'b0, c.ramp_len})
                && ($signed({1'b0, pos}) < upper);
  endfunction

endpackage

`default_nettype wire

[design/srpg_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module srpg_core #(
  parameter int COUNTER_BITS = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              step_en,
  input  wire [1:0]        op,
  input  wire              dir,
  input  srpg_pkg::cfg_t   cfg,
  output srpg_pkg::res_t   res_next
);
  import srpg_pkg::*;

  localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

  logic [15:0]             step_position, step_position_next;
  logic [COUNTER_BITS-1:0] phase_ticks, phase_ticks_next;
  logic [15:0]             half_period, half_period_next;
  logic                    pulse_high, pulse_high_next;
  logic                    move_active, move_active_next;
  logic                    dir_state, dir_state_next;
  logic                    sampling_armed, sampling_armed_next;
  logic [15:0]             next_target, next_target_next;
  logic [15:0]             accepted_count, accepted_count_next;
  logic                    done;

  logic [COUNTER_BITS-1:0] phase_inc;
  logic [15:0]             hp_dec;
  logic [15:0]             spacing;
  logic [16:0]             target_sum;
  logic                    due_cur;
  logic signed [16:0]      upper;

  always_comb begin
    step_position_next  = step_position;
    phase_ticks_next    = phase_ticks;
    half_period_next    = half_period;
    pulse_high_next     = pulse_high;
    move_active_next    = move_active;
    dir_state_next      = dir_state;
    sampling_armed_next = sampling_armed;
    next_target_next    = next_target;
    accepted_count_next = accepted_count;
    done                = 1'b0;

    upper      = cruise_upper(cfg);
    due_cur    = sampling_armed && in_cruise(move_active, step_position, cfg)
                 && (accepted_count < cfg.sample_count) && (step_position >= next_target);
    spacing    = (cfg.sample_spacing == 16'd0) ? 16'd1 : cfg.sample_spacing;
    target_sum = {1'b0, next_target} + {1'b0, spacing};
    phase_inc  = phase_ticks + 1'b1;
    hp_dec     = half_period;

    case (op_t'(op))
      OP_START: begin
        if (!move_active) begin
          step_position_next  = '0;
          phase_ticks_next    = '0;
          half_period_next    = cfg.start_delay;
          pulse_high_next     = 1'b1;
          move_active_next    = 1'b1;
          dir_state_next      = dir;
          sampling_armed_next = dir;
          next_target_next    = cfg.first_target;
          accepted_count_next = '0;
        end
      end
      OP_SAMPLE: begin
        if (due_cur) begin
          next_target_next    = target_sum[16] ? 16'hFFFF : target_sum[15:0];
          accepted_count_next = accepted_count + 16'd1;
        end
      end
      OP_TICK: begin
        if (move_active) begin
          phase_ticks_next = phase_inc;
          if (CMP_W'(phase_inc) >= CMP_W'(half_period)) begin
            phase_ticks_next = '0;
            if (pulse_high) begin
              pulse_high_next = 1'b0;
            end else begin
              // end of a full step: ramp the half-period, then advance or finish
              if ((step_position < {1'b0, cfg.ramp_len}) && (half_period > cfg.min_delay))
                hp_dec = half_period - 16'd1;
              half_period_next = hp_dec;
              if (($signed({1'b0, step_position}) > upper) && (hp_dec < cfg.start_delay))
                half_period_next = hp_dec + 16'd1;
              if (({1'b0, step_position} + 17'd1) >= {1'b0, cfg.move_len}) begin
                move_active_next = 1'b0;
                done             = 1'b1;
              end else begin
                step_position_next = step_position + 16'd1;
                pulse_high_next    = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_next.step_level      = pulse_high_next;
    res_next.direction_level = dir_state_next;
    res_next.moving          = move_active_next;
    res_next.constant_speed  = in_cruise(move_active_next, step_position_next, cfg);
    res_next.sample_due      = sampling_armed_next
                               && in_cruise(move_active_next, step_position_next, cfg)
                               && (accepted_count_next < cfg.sample_count)
                               && (step_position_next >= next_target_next);
    res_next.step_index      = step_position_next;
    res_next.samples_taken   = accepted_count_next;
    res_next.move_done       = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_position  <= '0;
      phase_ticks    <= '0;
      half_period    <= START_DELAY_RST;
      pulse_high     <= 1'b0;
      move_active    <= 1'b0;
      dir_state      <= 1'b0;
      sampling_armed <= 1'b0;
      next_target    <= '0;
      accepted_count <= '0;
    end else if (step_en) begin
      step_position  <= step_position_next;
      phase_ticks    <= phase_ticks_next;
      half_period    <= half_period_next;
      pulse_high     <= pulse_high_next;
      move_active    <= move_active_next;
      dir_state      <= dir_state_next;
      sampling_armed <= sampling_armed_next;
      next_target    <= next_target_next;
      accepted_count <= accepted_count_next;
    end
  end

endmodule

`default_nettype wire

[design/stepper_ramp_pulse_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes the input register, then the result register; the motion state
// updates in one pass of the tick logic. Throughput: one item per cycle with out_ready high.
// Reset (rst, synchronous, active high): registers return to their defaults, motion idle,
// pipeline empty. Configuration writes are taken every cycle (cfg_ready stays high).

module stepper_ramp_pulse_generator #(
  parameter int COUNTER_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // item input
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire [1:0]                            operation,
  input  wire                                  direction,
  // result output
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 step_level,
  output logic                                 direction_level,
  output logic                                 moving,
  output logic                                 constant_speed,
  output logic                                 sample_due,
  output logic [15:0]                          step_index,
  output logic [15:0]                          samples_taken,
  output logic                                 move_done,
  // register writes
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [srpg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [15:0]                           cfg_data
);
  import srpg_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [1:0] op_q;
  logic       dir_q;
  logic       advance;
  logic       s1_fire;
  res_t       res_next;
  res_t       res_q;

  assign cfg_ready = 1'b1;

  // Register file; a write lands in any cycle, so it must not overlap items in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_len        <= MOVE_LEN_RST;
      cfg.ramp_len        <= RAMP_LEN_RST;
      cfg.start_delay     <= START_DELAY_RST;
      cfg.min_delay       <= MIN_DELAY_RST;
      cfg.first_target    <= FIRST_TARGET_RST;
      cfg.sample_spacing  <= SAMPLE_SPACING_RST;
      cfg.sample_count    <= SAMPLE_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MOVE_LEN:        cfg.move_len        <= cfg_data;
        REG_RAMP_LEN:        cfg.ramp_len        <= cfg_data[14:0];
        REG_START_DELAY:     cfg.start_delay     <= cfg_data;
        REG_MIN_DELAY:       cfg.min_delay       <= cfg_data;
        REG_FIRST_TARGET:    cfg.first_target    <= cfg_data;
        REG_SAMPLE_SPACING:  cfg.sample_spacing  <= cfg_data;
        REG_SAMPLE_COUNT:    cfg.sample_count    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage 1 (input register) moves on whenever the result register is free or
  // being drained; an empty stage 1 still takes one item while a result waits.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign s1_fire  = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q  <= operation;
      dir_q <= direction;
    end
  end

  // Motion state lives in the core and commits when the item moves into the result register.
  srpg_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (s1_fire),
    .op       (op_q),
    .dir      (dir_q),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_q <= res_next;
    end
  end

  assign step_level      = res_q.step_level;
  assign direction_level = res_q.direction_level;
  assign moving          = res_q.moving;
  assign constant_speed  = res_q.constant_speed;
  assign sample_due      = res_q.sample_due;
  assign step_index      = res_q.step_index;
  assign samples_taken   = res_q.samples_taken;
  assign move_done       = res_q.move_done;

endmodule

`default_nettype wire
